/* sv/tme_pkg.sv */
// ----------------------------------------------------------------------------
// Tape machine executor package
// Sizes, opcodes, error codes and register indexes shared by the executor.
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int unsigned TAPE_DEPTH  = 4096;
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned CELL_BITS   = 32;
  localparam int unsigned PC_BITS     = 16;

  localparam int unsigned PTR_BITS    = 16;
  localparam int unsigned OUT_PC_W    = 16;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned IN_CHAR_W   = 9;
  localparam int unsigned SEED_W      = 32;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned ERR_W       = 3;

  localparam int unsigned TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int unsigned STK_AW  = $clog2(STACK_DEPTH);
  localparam int unsigned STK_DW  = $clog2(STACK_DEPTH + 1);

  localparam logic [PC_BITS-1:0] START_RESET = PC_BITS'(4);
  localparam logic [SEED_W-1:0]  SEED_RESET  = SEED_W'(1);
  localparam logic [SEED_W-1:0]  LFSR_TAPS   = 32'hD000_0001;
  localparam logic [32:0]        PC_MAX      = (33'd1 << PC_BITS) - 33'd1;

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [PC_BITS-1:0]   pc_t;
  typedef logic [PTR_BITS-1:0]  ptr_t;
  typedef logic [STK_DW-1:0]    depth_t;

  typedef enum logic [7:0] {
    OP_NOP        = 8'h00,
    OP_WRITE      = 8'h18,
    OP_READ       = 8'h19,
    OP_INC        = 8'h1A,
    OP_DEC        = 8'h1B,
    OP_RIGHT      = 8'h1C,
    OP_LEFT       = 8'h1D,
    OP_LOOP_OPEN  = 8'h1E,
    OP_LOOP_CLOSE = 8'h1F,
    OP_RAND       = 8'h20,
    OP_EXIT       = 8'h21,
    OP_CALL       = 8'h22,
    OP_RET        = 8'h23,
    OP_PUSH       = 8'h24,
    OP_POP        = 8'h25
  } opcode_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_UNDEF    = 3'd1,
    ERR_EMPTY    = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_RANGE    = 3'd4
  } err_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 1'b0,
    CFG_SEED  = 1'b1
  } cfg_reg_e;

  function automatic logic [SEED_W-1:0] seed_of(input logic [SEED_W-1:0] s);
    return (s == '0) ? SEED_W'(1) : s;
  endfunction

endpackage

/* sv/tme_ram.sv */
// ----------------------------------------------------------------------------
// Tape machine executor RAM
// Single write port, one registered read port, write-first on collision.
// ----------------------------------------------------------------------------
module tme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tape_machine_bytecode_executor_top.sv */
// ----------------------------------------------------------------------------
// Tape machine bytecode executor
// Executes one opcode per item against the tape, pointer, pc and stacks.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless the result side stalls; the tape and
// stack tops are read ahead at next pointer and depth, with write-first RAMs.
// Reset: a clearing pass zeroes all 4096 tape cells, one cell per cycle;
// no item is accepted during it, configuration writes are taken.
module tape_machine_bytecode_executor_top
  import tme_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            opcode_i,
  input  logic                  program_end_i,
  input  logic signed [IN_CHAR_W-1:0] in_char_i,

  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [OUT_PC_W-1:0]   next_pc_o,
  output logic                  out_valid_o,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  halted_o,
  output logic [ERR_W-1:0]      error_code_o
);

  logic               in_fire, cfg_fire;
  logic               clr_q;
  logic [TAPE_AW-1:0] clr_cnt_q;

  pc_t    pc_q, pc_d;
  ptr_t   ptr_q, ptr_d;
  logic [SEED_W-1:0] lfsr_q, lfsr_d, lfsr_step;
  logic   halt_q, halt_d;
  err_e   err_q, err_d;
  depth_t loop_depth_q, loop_depth_d;
  depth_t ret_depth_q, ret_depth_d;
  depth_t val_depth_q, val_depth_d;
  depth_t loop_top_idx, ret_top_idx, val_top_idx;

  cell_t  cur_cell, loop_top_unused;
  pc_t    loop_top, ret_top;
  cell_t  val_top;
  pc_t    pc_inc;
  logic   ptr_ok, uses_cell, exec_fault;
  logic   loop_push, loop_pop, ret_push, ret_pop, val_push, val_pop;
  logic   loop_full, loop_empty, ret_full, ret_empty, val_full, val_empty;

  logic               x_we, tape_we;
  cell_t              x_wd, tape_wd;
  logic [TAPE_AW-1:0] tape_wa;
  logic               o_valid;
  logic [CHAR_W-1:0]  o_char;

  logic                res_v_q;
  logic [OUT_PC_W-1:0] res_pc_q;
  logic                res_ov_q;
  logic [CHAR_W-1:0]   res_char_q;
  logic                res_halt_q;
  err_e                res_err_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = ~clr_q & (~res_v_q | res_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;

  assign pc_inc     = pc_q + PC_BITS'(1);
  assign ptr_ok     = {1'b0, ptr_q} < (PTR_BITS + 1)'(TAPE_DEPTH);
  assign loop_full  = loop_depth_q == STK_DW'(STACK_DEPTH);
  assign ret_full   = ret_depth_q  == STK_DW'(STACK_DEPTH);
  assign val_full   = val_depth_q  == STK_DW'(STACK_DEPTH);
  assign loop_empty = loop_depth_q == '0;
  assign ret_empty  = ret_depth_q  == '0;
  assign val_empty  = val_depth_q  == '0;
  assign lfsr_step  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
  assign loop_top_unused = '0;

  always_comb begin
    case (opcode_i)
      OP_INC, OP_DEC, OP_LOOP_CLOSE, OP_READ, OP_WRITE, OP_RAND,
      OP_CALL, OP_PUSH, OP_POP: uses_cell = 1'b1;
      default:                  uses_cell = 1'b0;
    endcase
  end

  always_comb begin
    pc_d       = pc_q;
    ptr_d      = ptr_q;
    lfsr_d     = lfsr_q;
    halt_d     = halt_q;
    err_d      = err_q;
    loop_push  = 1'b0;
    loop_pop   = 1'b0;
    ret_push   = 1'b0;
    ret_pop    = 1'b0;
    val_push   = 1'b0;
    val_pop    = 1'b0;
    x_we       = 1'b0;
    x_wd       = cur_cell;
    o_valid    = 1'b0;
    o_char     = '0;
    exec_fault = 1'b0;
    if (in_fire && !halt_q) begin
      if (program_end_i) begin
        halt_d = 1'b1;
      end else if (uses_cell && !ptr_ok) begin
        exec_fault = 1'b1;
        err_d      = ERR_RANGE;
      end else begin
        pc_d = pc_inc;
        case (opcode_i)
          OP_NOP: ;
          OP_INC: begin
            x_we = 1'b1;
            x_wd = cur_cell + CELL_BITS'(1);
          end
          OP_DEC: begin
            x_we = 1'b1;
            x_wd = cur_cell - CELL_BITS'(1);
          end
          OP_RIGHT: ptr_d = ptr_q + PTR_BITS'(1);
          OP_LEFT:  ptr_d = ptr_q - PTR_BITS'(1);
          OP_LOOP_OPEN: begin
            if (loop_full) begin
              exec_fault = 1'b1;
              err_d      = ERR_OVERFLOW;
            end else begin
              loop_push = 1'b1;
            end
          end
          OP_LOOP_CLOSE: begin
            if (cur_cell != '0) begin
              if (loop_empty) begin
                exec_fault = 1'b1;
                err_d      = ERR_EMPTY;
              end else begin
                loop_pop = 1'b1;
                pc_d     = loop_top;
              end
            end
          end
          OP_READ: begin
            x_we = 1'b1;
            x_wd = CELL_BITS'(in_char_i);
          end
          OP_WRITE: begin
            o_valid = 1'b1;
            o_char  = cur_cell[CHAR_W-1:0];
          end
          OP_RAND: begin
            lfsr_d = lfsr_step;
            x_we   = 1'b1;
            x_wd   = CELL_BITS'(lfsr_step);
          end
          OP_EXIT: halt_d = 1'b1;
          OP_CALL: begin
            if (33'(cur_cell) > PC_MAX) begin
              exec_fault = 1'b1;
              err_d      = ERR_RANGE;
            end else if (ret_full) begin
              exec_fault = 1'b1;
              err_d      = ERR_OVERFLOW;
            end else begin
              ret_push = 1'b1;
              pc_d     = PC_BITS'(cur_cell);
            end
          end
          OP_RET: begin
            if (ret_empty) begin
              exec_fault = 1'b1;
              err_d      = ERR_EMPTY;
            end else begin
              ret_pop = 1'b1;
              pc_d    = ret_top;
            end
          end
          OP_PUSH: begin
            if (val_full) begin
              exec_fault = 1'b1;
              err_d      = ERR_OVERFLOW;
            end else begin
              val_push = 1'b1;
            end
          end
          OP_POP: begin
            if (val_empty) begin
              exec_fault = 1'b1;
              err_d      = ERR_EMPTY;
            end else begin
              val_pop = 1'b1;
              x_we    = 1'b1;
              x_wd    = val_top;
            end
          end
          default: begin
            exec_fault = 1'b1;
            err_d      = ERR_UNDEF;
          end
        endcase
        if (exec_fault) begin
          pc_d      = pc_q;
          ptr_d     = ptr_q;
          lfsr_d    = lfsr_q;
          loop_push = 1'b0;
          loop_pop  = 1'b0;
          ret_push  = 1'b0;
          ret_pop   = 1'b0;
          val_push  = 1'b0;
          val_pop   = 1'b0;
          x_we      = 1'b0;
          o_valid   = 1'b0;
          o_char    = '0;
        end
      end
      if (exec_fault) begin
        halt_d = 1'b1;
      end
    end
  end

  always_comb begin
    loop_depth_d = loop_depth_q;
    ret_depth_d  = ret_depth_q;
    val_depth_d  = val_depth_q;
    if (loop_push) begin
      loop_depth_d = loop_depth_q + STK_DW'(1);
    end else if (loop_pop) begin
      loop_depth_d = loop_depth_q - STK_DW'(1);
    end
    if (ret_push) begin
      ret_depth_d = ret_depth_q + STK_DW'(1);
    end else if (ret_pop) begin
      ret_depth_d = ret_depth_q - STK_DW'(1);
    end
    if (val_push) begin
      val_depth_d = val_depth_q + STK_DW'(1);
    end else if (val_pop) begin
      val_depth_d = val_depth_q - STK_DW'(1);
    end
  end

  assign loop_top_idx = loop_depth_d - STK_DW'(1);
  assign ret_top_idx  = ret_depth_d  - STK_DW'(1);
  assign val_top_idx  = val_depth_d  - STK_DW'(1);

  assign tape_we = clr_q | x_we;
  assign tape_wa = clr_q ? clr_cnt_q : ptr_q[TAPE_AW-1:0];
  assign tape_wd = clr_q ? loop_top_unused : x_wd;

  tme_ram #(.WIDTH(CELL_BITS), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_wa),
    .wdata_i (tape_wd),
    .raddr_i (ptr_d[TAPE_AW-1:0]),
    .rdata_o (cur_cell)
  );

  tme_ram #(.WIDTH(PC_BITS), .DEPTH(STACK_DEPTH)) u_loop_stack (
    .clk_i   (clk_i),
    .we_i    (loop_push),
    .waddr_i (loop_depth_q[STK_AW-1:0]),
    .wdata_i (pc_q),
    .raddr_i (loop_top_idx[STK_AW-1:0]),
    .rdata_o (loop_top)
  );

  tme_ram #(.WIDTH(PC_BITS), .DEPTH(STACK_DEPTH)) u_ret_stack (
    .clk_i   (clk_i),
    .we_i    (ret_push),
    .waddr_i (ret_depth_q[STK_AW-1:0]),
    .wdata_i (pc_inc),
    .raddr_i (ret_top_idx[STK_AW-1:0]),
    .rdata_o (ret_top)
  );

  tme_ram #(.WIDTH(CELL_BITS), .DEPTH(STACK_DEPTH)) u_val_stack (
    .clk_i   (clk_i),
    .we_i    (val_push),
    .waddr_i (val_depth_q[STK_AW-1:0]),
    .wdata_i (cur_cell),
    .raddr_i (val_top_idx[STK_AW-1:0]),
    .rdata_o (val_top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + TAPE_AW'(1);
      if (clr_cnt_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= START_RESET;
      ptr_q        <= '0;
      lfsr_q       <= SEED_RESET;
      halt_q       <= 1'b0;
      err_q        <= ERR_NONE;
      loop_depth_q <= '0;
      ret_depth_q  <= '0;
      val_depth_q  <= '0;
    end else begin
      if (cfg_fire && (cfg_index_i == CFG_START)) begin
        pc_q <= PC_BITS'(cfg_data_i[OUT_PC_W-1:0]);
      end else begin
        pc_q <= pc_d;
      end
      ptr_q        <= ptr_d;
      if (cfg_fire && (cfg_index_i == CFG_SEED)) begin
        lfsr_q <= seed_of(cfg_data_i);
      end else begin
        lfsr_q <= lfsr_d;
      end
      halt_q       <= halt_d;
      err_q        <= err_d;
      loop_depth_q <= loop_depth_d;
      ret_depth_q  <= ret_depth_d;
      val_depth_q  <= val_depth_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (in_fire) begin
      res_v_q <= 1'b1;
    end else if (res_ready_i) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_pc_q   <= OUT_PC_W'(pc_d);
      res_ov_q   <= o_valid;
      res_char_q <= o_char;
      res_halt_q <= halt_d;
      res_err_q  <= err_d;
    end
  end

  assign res_valid_o  = res_v_q;
  assign next_pc_o    = res_pc_q;
  assign out_valid_o  = res_ov_q;
  assign out_char_o   = res_char_q;
  assign halted_o     = res_halt_q;
  assign error_code_o = res_err_q;

`ifndef SYNTHESIS
  a_halt_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q && in_fire && !cfg_fire |=> $stable(pc_q))
    else $error("pc moved on a halted machine");

  a_fault_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && exec_fault |=> res_halt_q && (res_err_q != ERR_NONE) && !res_ov_q)
    else $error("fault not reported in result");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |-> halt_q)
    else $error("error code set without halt");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (loop_depth_q <= STK_DW'(STACK_DEPTH)) && (ret_depth_q <= STK_DW'(STACK_DEPTH))
      && (val_depth_q <= STK_DW'(STACK_DEPTH)))
    else $error("stack depth past capacity");
`endif

endmodule

/* test/tape_machine_bytecode_executor_checker.sv */
// ----------------------------------------------------------------------------
// Tape machine executor checker
// Watches the configuration, opcode and result channels, predicts every
// result from its own copy of the machine state and compares field by field.
// ----------------------------------------------------------------------------
module tape_machine_bytecode_executor_checker
  import tme_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            opcode_i,
  input  logic                  program_end_i,
  input  logic [IN_CHAR_W-1:0]  in_char_i,

  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [OUT_PC_W-1:0]   next_pc_i,
  input  logic                  out_valid_i,
  input  logic [CHAR_W-1:0]     out_char_i,
  input  logic                  halted_i,
  input  logic [ERR_W-1:0]      error_code_i,

  output int                    fail_count_o,
  output int                    outstanding_o,
  output int                    results_o,
  output cell_t                 cur_word_o,
  output ptr_t                  cur_ptr_o,
  output int                    loop_depth_o,
  output int                    call_depth_o,
  output int                    value_depth_o,
  output logic [ERR_W-1:0]      error_o
);

  typedef struct packed {
    logic [OUT_PC_W-1:0] next_pc;
    logic                out_valid;
    logic [CHAR_W-1:0]   out_char;
    logic                halted;
    logic [ERR_W-1:0]    error_code;
  } step_result_t;

  cell_t             tape [TAPE_DEPTH];
  pc_t               loop_marks [STACK_DEPTH];
  pc_t               return_stack [STACK_DEPTH];
  cell_t             value_stack [STACK_DEPTH];
  ptr_t              ptr;
  pc_t               pc;
  int                loop_depth;
  int                call_depth;
  int                value_depth;
  logic [SEED_W-1:0] lfsr;
  logic              halt_flag;
  err_e              sticky_err;

  step_result_t      pending_results [$];
  step_result_t      want;
  step_result_t      got_step;
  int                mismatches = 0;
  int                results_seen = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic execute_opcode(input logic [7:0] op, input logic pend,
                                input logic [IN_CHAR_W-1:0] ch, output step_result_t r);
    pc_t                nxt;
    err_e               fault;
    logic               emit;
    logic [CHAR_W-1:0]  chr;
    logic               in_tape;
    logic               touches;
    cell_t              word;
    logic [TAPE_AW-1:0] slot;
    nxt     = pc + PC_BITS'(1);
    fault   = ERR_NONE;
    emit    = 1'b0;
    chr     = '0;
    in_tape = ptr < TAPE_DEPTH;
    slot    = ptr[TAPE_AW-1:0];
    word    = in_tape ? tape[slot] : '0;
    case (op)
      OP_INC, OP_DEC, OP_LOOP_CLOSE, OP_READ, OP_WRITE, OP_RAND, OP_CALL, OP_PUSH,
      OP_POP: touches = 1'b1;
      default: touches = 1'b0;
    endcase
    if (!halt_flag) begin
      if (pend) begin
        halt_flag = 1'b1;
      end else begin
        if (touches && !in_tape) begin
          fault = ERR_RANGE;
        end else begin
          case (op)
            OP_NOP: ;
            OP_INC: tape[slot] = word + CELL_BITS'(1);
            OP_DEC: tape[slot] = word - CELL_BITS'(1);
            OP_RIGHT: ptr = ptr + PTR_BITS'(1);
            OP_LEFT: ptr = ptr - PTR_BITS'(1);
            OP_LOOP_OPEN: begin
              if (loop_depth >= STACK_DEPTH) begin
                fault = ERR_OVERFLOW;
              end else begin
                loop_marks[loop_depth] = pc;
                loop_depth++;
              end
            end
            OP_LOOP_CLOSE: begin
              if (word != '0) begin
                if (loop_depth == 0) begin
                  fault = ERR_EMPTY;
                end else begin
                  loop_depth--;
                  nxt = loop_marks[loop_depth];
                end
              end
            end
            OP_READ: tape[slot] = {{(CELL_BITS-IN_CHAR_W){ch[IN_CHAR_W-1]}}, ch};
            OP_WRITE: begin
              emit = 1'b1;
              chr  = word[CHAR_W-1:0];
            end
            OP_RAND: begin
              if (lfsr[0]) begin
                lfsr = (lfsr >> 1) ^ LFSR_TAPS;
              end else begin
                lfsr = lfsr >> 1;
              end
              tape[slot] = lfsr;
            end
            OP_EXIT: halt_flag = 1'b1;
            OP_CALL: begin
              if (word > cell_t'(PC_MAX)) begin
                fault = ERR_RANGE;
              end else if (call_depth >= STACK_DEPTH) begin
                fault = ERR_OVERFLOW;
              end else begin
                return_stack[call_depth] = nxt;
                call_depth++;
                nxt = pc_t'(word);
              end
            end
            OP_RET: begin
              if (call_depth == 0) begin
                fault = ERR_EMPTY;
              end else begin
                call_depth--;
                nxt = return_stack[call_depth];
              end
            end
            OP_PUSH: begin
              if (value_depth >= STACK_DEPTH) begin
                fault = ERR_OVERFLOW;
              end else begin
                value_stack[value_depth] = word;
                value_depth++;
              end
            end
            OP_POP: begin
              if (value_depth == 0) begin
                fault = ERR_EMPTY;
              end else begin
                value_depth--;
                tape[slot] = value_stack[value_depth];
              end
            end
            default: fault = ERR_UNDEF;
          endcase
        end
        if (fault != ERR_NONE) begin
          halt_flag  = 1'b1;
          sticky_err = fault;
          emit       = 1'b0;
          chr        = '0;
        end else begin
          pc = nxt;
        end
      end
    end
    r.next_pc    = OUT_PC_W'(pc);
    r.out_valid  = emit;
    r.out_char   = chr;
    r.halted     = halt_flag;
    r.error_code = sticky_err;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPE_DEPTH; i++) begin
        tape[i] = '0;
      end
      ptr         = '0;
      pc          = START_RESET;
      loop_depth  = 0;
      call_depth  = 0;
      value_depth = 0;
      lfsr        = SEED_RESET;
      halt_flag   = 1'b0;
      sticky_err  = ERR_NONE;
      pending_results.delete();
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with no item outstanding");
        end else begin
          want = pending_results.pop_front();
          got_step = {next_pc_i, out_valid_i, out_char_i, halted_i, error_code_i};
          if (got_step.next_pc !== want.next_pc)
            report_mismatch($sformatf("next_pc 0x%0h, expected 0x%0h",
                                      got_step.next_pc, want.next_pc));
          if (got_step.out_valid !== want.out_valid)
            report_mismatch($sformatf("out_valid %0b, expected %0b",
                                      got_step.out_valid, want.out_valid));
          if (got_step.out_char !== want.out_char)
            report_mismatch($sformatf("out_char 0x%0h, expected 0x%0h",
                                      got_step.out_char, want.out_char));
          if (got_step.halted !== want.halted)
            report_mismatch($sformatf("halted %0b, expected %0b",
                                      got_step.halted, want.halted));
          if (got_step.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got_step.error_code, want.error_code));
        end
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_START: pc = cfg_data_i[PC_BITS-1:0];
          CFG_SEED: lfsr = (cfg_data_i == '0) ? SEED_W'(1) : cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        execute_opcode(opcode_i, program_end_i, in_char_i, want);
        pending_results = {pending_results, want};
      end
    end
    fail_count_o  = mismatches;
    outstanding_o = pending_results.size();
    results_o     = results_seen;
    cur_word_o    = (ptr < TAPE_DEPTH) ? tape[ptr[TAPE_AW-1:0]] : '0;
    cur_ptr_o     = ptr;
    loop_depth_o  = loop_depth;
    call_depth_o  = call_depth;
    value_depth_o = value_depth;
    error_o       = sticky_err;
  end

endmodule

/* test/tape_machine_bytecode_executor_top_test.sv */
// ----------------------------------------------------------------------------
// Tape machine executor testbench
// Drives directed and steered random opcode streams with bursty input and a
// stalling result side, rewrites the start address and seed between phases,
// and ends on one halting cause followed by noise while halted.
// ----------------------------------------------------------------------------
module tape_machine_bytecode_executor_top_test;
  import tme_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_AFTER  = 300;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_NOISE  = 40;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = CFG_START;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   opcode = OP_NOP;
  logic                         program_end = 1'b0;
  logic signed [IN_CHAR_W-1:0]  in_char = '0;

  logic                         res_valid;
  logic                         res_ready = 1'b0;
  logic [OUT_PC_W-1:0]          next_pc;
  logic                         out_valid;
  logic [CHAR_W-1:0]            out_char;
  logic                         halted;
  logic [ERR_W-1:0]             error_code;

  int                           fail_count;
  int                           outstanding;
  int                           results_checked;
  int                           loops_open;
  int                           calls_open;
  int                           values_held;
  cell_t                        cur_word;
  ptr_t                         cur_ptr;
  logic [ERR_W-1:0]             final_error;

  int                           burst_left = 0;
  int                           items_sent = 0;
  int                           cfg_writes = 0;
  int                           cycle_count = 0;

  tape_machine_bytecode_executor_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (opcode),
    .program_end_i (program_end),
    .in_char_i     (in_char),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .next_pc_o     (next_pc),
    .out_valid_o   (out_valid),
    .out_char_o    (out_char),
    .halted_o      (halted),
    .error_code_o  (error_code)
  );

  tape_machine_bytecode_executor_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .opcode_i      (opcode),
    .program_end_i (program_end),
    .in_char_i     (in_char),
    .res_valid_i   (res_valid),
    .res_ready_i   (res_ready),
    .next_pc_i     (next_pc),
    .out_valid_i   (out_valid),
    .out_char_i    (out_char),
    .halted_i      (halted),
    .error_code_i  (error_code),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .results_o     (results_checked),
    .cur_word_o    (cur_word),
    .cur_ptr_o     (cur_ptr),
    .loop_depth_o  (loops_open),
    .call_depth_o  (calls_open),
    .value_depth_o (values_held),
    .error_o       (final_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [IN_CHAR_W-1:0] random_char();
    return ($urandom_range(0, 7) == 0) ? {IN_CHAR_W{1'b1}}
                                       : IN_CHAR_W'($urandom_range(0, 511));
  endfunction

  // Pick an opcode that keeps the machine running, leaning toward growing or
  // shrinking the stacks.
  function automatic logic [7:0] pick_opcode(input bit grow);
    logic [7:0] cand;
    logic       ok;
    int         tries;
    int         w;
    cand  = OP_NOP;
    ok    = 1'b0;
    tries = 0;
    if (cur_ptr >= TAPE_DEPTH) begin
      cand = (cur_ptr == '1) ? OP_RIGHT : OP_LEFT;
      ok   = 1'b1;
    end
    while (!ok && tries < 8) begin
      w = $urandom_range(0, 26);
      if (w < 6) begin
        cand = grow ? OP_LOOP_OPEN : OP_LOOP_CLOSE;
      end else if (w < 12) begin
        cand = grow ? OP_PUSH : OP_POP;
      end else if (w < 16) begin
        cand = grow ? OP_CALL : OP_RET;
      end else begin
        case (w)
          16: cand = grow ? OP_LOOP_CLOSE : OP_LOOP_OPEN;
          17: cand = grow ? OP_POP : OP_PUSH;
          18: cand = grow ? OP_RET : OP_CALL;
          19: cand = OP_NOP;
          20: cand = OP_INC;
          21: cand = OP_DEC;
          22: cand = OP_RIGHT;
          23: cand = OP_LEFT;
          24: cand = OP_READ;
          25: cand = OP_WRITE;
          default: cand = OP_RAND;
        endcase
      end
      case (cand)
        OP_RIGHT: ok = cur_ptr < 31;
        OP_LEFT: ok = (cur_ptr != 0) || ($urandom_range(0, 19) == 0);
        OP_LOOP_OPEN: ok = loops_open < STACK_DEPTH;
        OP_LOOP_CLOSE: ok = (cur_word == '0) || (loops_open != 0);
        OP_CALL: ok = (cur_word <= cell_t'(PC_MAX)) && (calls_open < STACK_DEPTH);
        OP_RET: ok = calls_open != 0;
        OP_PUSH: ok = values_held < STACK_DEPTH;
        OP_POP: ok = values_held != 0;
        default: ok = 1'b1;
      endcase
      tries++;
    end
    return ok ? cand : OP_NOP;
  endfunction

  task automatic send_item(input logic [7:0] op, input logic pend,
                           input logic [IN_CHAR_W-1:0] ch);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid    = 1'b1;
    opcode      = op;
    program_end = pend;
    in_char     = ch;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  // Result side: shifting stall patterns, plus one long hold-off.
  initial begin
    int taken;
    int mode;
    int mode_left;
    bit held;
    taken     = 0;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) taken++;
      @(negedge clk);
      if (!held && taken >= HOLD_AFTER) begin
        held      = 1'b1;
        res_ready = 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0: res_ready = 1'b1;
        1: res_ready = (mode_left % 4) != 0;
        2: res_ready = 1'($urandom_range(0, 1));
        default: res_ready = $urandom_range(0, 4) == 0;
      endcase
    end
  end

  initial begin
    logic [7:0]        op;
    bit                grow;
    int                seg;
    logic [PC_BITS-1:0] start_val;
    logic [SEED_W-1:0]  seed_val;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(OP_NOP, 1'b0, random_char());
    send_item(OP_INC, 1'b0, random_char());
    send_item(OP_WRITE, 1'b0, random_char());
    send_item(OP_DEC, 1'b0, random_char());
    send_item(OP_DEC, 1'b0, random_char());
    send_item(OP_WRITE, 1'b0, random_char());
    send_item(OP_READ, 1'b0, 9'd255);
    send_item(OP_WRITE, 1'b0, random_char());
    send_item(OP_READ, 1'b0, 9'h1FF);
    send_item(OP_PUSH, 1'b0, random_char());
    send_item(OP_READ, 1'b0, 9'h100);
    send_item(OP_POP, 1'b0, random_char());
    send_item(OP_WRITE, 1'b0, random_char());
    send_item(OP_RAND, 1'b0, random_char());
    send_item(OP_RAND, 1'b0, random_char());
    send_item(OP_WRITE, 1'b0, random_char());
    send_item(OP_LEFT, 1'b0, random_char());
    send_item(OP_RIGHT, 1'b0, random_char());
    send_item(OP_LOOP_OPEN, 1'b0, random_char());
    send_item(OP_INC, 1'b0, random_char());
    send_item(OP_LOOP_CLOSE, 1'b0, random_char());
    send_item(OP_READ, 1'b0, 9'd0);
    send_item(OP_LOOP_CLOSE, 1'b0, random_char());
    send_item(OP_READ, 1'b0, 9'd5);
    send_item(OP_CALL, 1'b0, random_char());
    send_item(OP_RET, 1'b0, random_char());

    for (int phase = 0; phase < PHASES; phase++) begin
      in_valid   = 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      case (phase)
        0: begin
          start_val = '0;
          seed_val  = '0;
        end
        1: begin
          start_val = '1;
          seed_val  = '1;
        end
        3: begin
          start_val = START_RESET;
          seed_val  = SEED_RESET;
        end
        default: begin
          start_val = PC_BITS'($urandom);
          seed_val  = $urandom;
        end
      endcase
      cfg_write(CFG_START, CFG_DATA_W'(start_val));
      cfg_write(CFG_SEED, seed_val);
      grow = $urandom_range(0, 1);
      seg  = $urandom_range(100, 400);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (seg == 0) begin
          grow = !grow;
          seg  = $urandom_range(100, 400);
        end
        seg--;
        send_item(pick_opcode(grow), 1'b0, random_char());
      end
    end

    // Bring the pointer back onto the tape, then halt the machine one way.
    while (cur_ptr >= TAPE_DEPTH)
      send_item((cur_ptr == '1) ? OP_RIGHT : OP_LEFT, 1'b0, random_char());
    case ($urandom_range(0, 6))
      0: send_item(OP_EXIT, 1'b0, random_char());
      1: send_item(OP_NOP, 1'b1, random_char());
      2: send_item(8'($urandom_range(8'h26, 8'hFF)), 1'b0, random_char());
      3: begin
        op = $urandom_range(0, 1) ? OP_POP : OP_RET;
        while (((op == OP_POP) ? values_held : calls_open) != 0)
          send_item(op, 1'b0, random_char());
        send_item(op, 1'b0, random_char());
      end
      4: begin
        op = $urandom_range(0, 1) ? OP_PUSH : OP_LOOP_OPEN;
        while (((op == OP_PUSH) ? values_held : loops_open) < STACK_DEPTH)
          send_item(op, 1'b0, random_char());
        send_item(op, 1'b0, random_char());
      end
      5: begin
        send_item(OP_READ, 1'b0, 9'h1FF);
        send_item(OP_CALL, 1'b0, random_char());
      end
      default: begin
        while (cur_ptr != 0) send_item(OP_LEFT, 1'b0, random_char());
        send_item(OP_LEFT, 1'b0, random_char());
        send_item(OP_INC, 1'b0, random_char());
      end
    endcase
    repeat (TAIL_NOISE)
      send_item(8'($urandom), 1'($urandom), IN_CHAR_W'($urandom));
    in_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Run covered %0d opcodes and %0d results over %0d register writes.",
             items_sent, results_checked, cfg_writes);
    $display("Machine ended halted with sticky error code %0d.", final_error);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tme_pkg.sv
sv/tme_ram.sv
sv/tape_machine_bytecode_executor_top.sv
test/tape_machine_bytecode_executor_checker.sv
test/tape_machine_bytecode_executor_top_test.sv
